// ===== rtl/iva_pkg.sv =====
// Shared types and constants for the interrupt vector allocator.
// Used by iva_ctrl, iva_datapath and interrupt_vector_allocator_unit.
`timescale 1ns / 1ps

package iva_pkg;

  // Default table sizes
  localparam int NUM_IRQS_DEF    = 256;
  localparam int NUM_VECTORS_DEF = 256;

  // Field widths fixed by the interface
  localparam int OP_W     = 3;
  localparam int IRQ_IN_W = 9;
  localparam int VEC_IN_W = 8;
  localparam int STATUS_W = 3;
  localparam int IRQ_OUT_W = 8;

  // Free-vector scan: 16 vectors per cycle over the 8-bit vector space
  localparam int SCAN_LOG = 4;
  localparam int SCAN_W   = 2 ** SCAN_LOG;
  localparam int CHUNK_W  = VEC_IN_W - SCAN_LOG;
  localparam int VEC_SPACE = 2 ** VEC_IN_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_BIND     = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE     = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_IRQ  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SPURIOUS = 3'd4;
  localparam logic [STATUS_W-1:0] ST_STALE    = 3'd5;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_DYN_START = 2'd0;
  localparam logic [1:0] REG_DYN_END   = 2'd1;
  localparam logic [1:0] REG_FIX_START = 2'd2;

  localparam logic [7:0] DYN_START_RST = 8'd32;
  localparam logic [7:0] DYN_END_RST   = 8'd223;
  localparam logic [7:0] FIX_START_RST = 8'd224;

  typedef struct packed {
    logic [7:0] dyn_start;
    logic [7:0] dyn_end;
    logic [7:0] fix_start;
  } iva_cfg_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;    // latch request, first table reads
    logic read2;      // dependent table reads
    logic exec_fire;  // commit non-scan result and table updates
    logic scan_start; // load first scan chunk
    logic scan_step;  // examine one chunk
    logic alloc_fire; // commit scan result
  } iva_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic need_scan;
    logic out_free;
    logic scan_hit;
    logic scan_last;
  } iva_sts_t;

endpackage

// ===== rtl/iva_ctrl.sv =====
// Sequencing state machine for the interrupt vector allocator.
// Depends on iva_pkg for the command and status structs.
`timescale 1ns / 1ps

module iva_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  iva_pkg::iva_sts_t sts,
  output iva_pkg::iva_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ2 = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ2;
        end
      end
      S_READ2: begin
        cmd.read2  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.need_scan) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (sts.out_free) begin
          cmd.exec_fire = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_hit || sts.scan_last) begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // hold the found vector until the output register frees up
        if (sts.out_free) begin
          cmd.alloc_fire = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/iva_datapath.sv =====
// Tables, valid bits, free-vector scan and output register of the allocator.
// Depends on iva_pkg; driven by iva_ctrl commands.
`timescale 1ns / 1ps

module iva_datapath #(
  parameter int NUM_IRQS    = iva_pkg::NUM_IRQS_DEF,
  parameter int NUM_VECTORS = iva_pkg::NUM_VECTORS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  iva_pkg::iva_cmd_t              cmd,
  output iva_pkg::iva_sts_t              sts,
  input  iva_pkg::iva_cfg_t              cfg,
  input  logic [iva_pkg::OP_W-1:0]       operation,
  input  logic [iva_pkg::IRQ_IN_W-1:0]   irq_number,
  input  logic [iva_pkg::VEC_IN_W-1:0]   vector_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [iva_pkg::STATUS_W-1:0]   status,
  output logic                           vector_valid,
  output logic [iva_pkg::VEC_IN_W-1:0]   vector_out,
  output logic                           deliver,
  output logic [iva_pkg::IRQ_OUT_W-1:0]  irq_out
);

  localparam int IRQ_W = $clog2(NUM_IRQS);
  localparam int VEC_W = $clog2(NUM_VECTORS);
  localparam int LW    = iva_pkg::SCAN_LOG;
  localparam int CW    = iva_pkg::CHUNK_W;
  localparam logic [iva_pkg::IRQ_IN_W-1:0] IRQ_LIMIT = iva_pkg::IRQ_IN_W'(NUM_IRQS);
  localparam logic [iva_pkg::VEC_IN_W:0]   VEC_LIMIT = (iva_pkg::VEC_IN_W + 1)'(NUM_VECTORS);

  // Table storage: values in memories, valid bits in flops
  logic [VEC_W-1:0] fwd_mem [NUM_IRQS];
  logic [IRQ_W-1:0] rev_mem [NUM_VECTORS];
  logic [NUM_IRQS-1:0]    fwd_valid;
  logic [NUM_VECTORS-1:0] rev_valid;

  // Latched request
  logic [iva_pkg::OP_W-1:0]     op_q;
  logic [iva_pkg::IRQ_IN_W-1:0] irq_q;
  logic [iva_pkg::VEC_IN_W-1:0] vec_q;

  // fwd_q1 = fwd[irq], rev_q1 = rev[vec], fwd_rd = fwd[rev_q1], rev_rd = rev[fwd_q1]
  logic [VEC_W-1:0] fwd_rd;
  logic [VEC_W-1:0] fwd_q1;
  logic [IRQ_W-1:0] rev_rd;
  logic [IRQ_W-1:0] rev_q1;

  // Scan state
  logic [CW-1:0]                scan_chunk;
  logic                         scan_found;
  logic [iva_pkg::VEC_IN_W-1:0] scan_vec;

  logic [IRQ_W-1:0] irq_idx;
  logic [VEC_W-1:0] vec_idx;
  logic             irq_ok;
  logic             vec_ok;
  logic             out_free;

  logic [iva_pkg::VEC_SPACE-1:0] free_map;
  logic [iva_pkg::SCAN_W-1:0]    chunk_free;
  logic [iva_pkg::SCAN_W-1:0]    lane_ok;
  logic                          lane_hit;
  logic [LW-1:0]                 lane_sel;

  // Result and write requests from the decode
  logic [iva_pkg::STATUS_W-1:0]  ex_status;
  logic                          ex_vvalid;
  logic [iva_pkg::VEC_IN_W-1:0]  ex_vout;
  logic                          ex_deliver;
  logic [iva_pkg::IRQ_OUT_W-1:0] ex_iout;
  logic                          ex_need_scan;
  logic                          ex_fwd_set;
  logic                          ex_fwd_clr;
  logic                          ex_rev_set;
  logic                          ex_rev_clr;
  logic [VEC_W-1:0]              ex_rev_addr;

  logic             fwd_set;
  logic             fwd_clr;
  logic [IRQ_W-1:0] fwd_wa;
  logic [VEC_W-1:0] fwd_wd;
  logic             rev_set;
  logic             rev_clr;
  logic [VEC_W-1:0] rev_wa;
  logic [IRQ_W-1:0] rev_wd;

  assign irq_idx  = irq_q[IRQ_W-1:0];
  assign vec_idx  = vec_q[VEC_W-1:0];
  assign irq_ok   = irq_q < IRQ_LIMIT;
  assign vec_ok   = {1'b0, vec_q} < VEC_LIMIT;
  assign out_free = !out_valid || out_ready;

  // Capture request and run the two read phases
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      irq_q  <= irq_number;
      vec_q  <= vector_in;
      fwd_rd <= fwd_mem[irq_number[IRQ_W-1:0]];
    end else if (cmd.read2) begin
      fwd_q1 <= fwd_rd;
      fwd_rd <= fwd_mem[rev_rd];
    end
    if (fwd_set) begin
      fwd_mem[fwd_wa] <= fwd_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rev_rd <= rev_mem[vector_in[VEC_W-1:0]];
    end else if (cmd.read2) begin
      rev_q1 <= rev_rd;
      rev_rd <= rev_mem[fwd_rd];
    end
    if (rev_set) begin
      rev_mem[rev_wa] <= rev_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= '0;
      rev_valid <= '0;
    end else begin
      if (fwd_set) begin
        fwd_valid[fwd_wa] <= 1'b1;
      end
      if (fwd_clr) begin
        fwd_valid[fwd_wa] <= 1'b0;
      end
      if (rev_set) begin
        rev_valid[rev_wa] <= 1'b1;
      end
      if (rev_clr) begin
        rev_valid[rev_wa] <= 1'b0;
      end
    end
  end

  // Free map over the full 8-bit vector space; vectors past the table read busy
  for (genvar gi = 0; gi < iva_pkg::VEC_SPACE; gi++) begin : g_free
    if (gi < NUM_VECTORS) begin : g_in
      assign free_map[gi] = ~rev_valid[gi];
    end else begin : g_out
      assign free_map[gi] = 1'b0;
    end
  end

  assign chunk_free = free_map[{scan_chunk, {LW{1'b0}}} +: iva_pkg::SCAN_W];

  always_comb begin
    logic [iva_pkg::VEC_IN_W-1:0] cand;
    lane_ok  = '0;
    lane_hit = 1'b0;
    lane_sel = '0;
    for (int i = 0; i < iva_pkg::SCAN_W; i++) begin
      cand       = {scan_chunk, LW'(i)};
      lane_ok[i] = chunk_free[i] && (cand >= cfg.dyn_start) && (cand <= cfg.dyn_end);
    end
    // lowest free lane wins
    for (int i = iva_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (lane_ok[i]) begin
        lane_hit = 1'b1;
        lane_sel = LW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_chunk <= cfg.dyn_start[iva_pkg::VEC_IN_W-1:LW];
    end else if (cmd.scan_step) begin
      scan_found <= lane_hit;
      scan_vec   <= {scan_chunk, lane_sel};
      scan_chunk <= scan_chunk + CW'(1);
    end
  end

  // Decode of the latched request against the table reads
  always_comb begin
    ex_status    = iva_pkg::ST_OK;
    ex_vvalid    = 1'b0;
    ex_vout      = '0;
    ex_deliver   = 1'b0;
    ex_iout      = '0;
    ex_need_scan = 1'b0;
    ex_fwd_set   = 1'b0;
    ex_fwd_clr   = 1'b0;
    ex_rev_set   = 1'b0;
    ex_rev_clr   = 1'b0;
    ex_rev_addr  = vec_idx;
    if (op_q <= iva_pkg::OP_LOOKUP && !irq_ok) begin
      ex_status = iva_pkg::ST_BAD_IRQ;
    end else begin
      unique case (op_q)
        iva_pkg::OP_BIND: begin
          if (!vec_ok) begin
            ex_status = iva_pkg::ST_BAD_IRQ;
          end else begin
            ex_fwd_set = 1'b1;
            ex_rev_set = 1'b1;
          end
        end
        iva_pkg::OP_ALLOC: begin
          if (fwd_valid[irq_idx]) begin
            if (rev_valid[fwd_q1] && rev_rd == irq_idx) begin
              ex_vvalid = 1'b1;
              ex_vout   = iva_pkg::VEC_IN_W'(fwd_q1);
            end else begin
              ex_status = iva_pkg::ST_MISMATCH;
            end
          end else if (cfg.dyn_start > cfg.dyn_end) begin
            ex_status = iva_pkg::ST_NO_FREE;
          end else begin
            ex_need_scan = 1'b1;
          end
        end
        iva_pkg::OP_FREE: begin
          ex_rev_addr = fwd_q1;
          if (fwd_valid[irq_idx] && iva_pkg::VEC_IN_W'(fwd_q1) < cfg.fix_start) begin
            ex_fwd_clr = 1'b1;
            // drop the reverse entry only if it still points back here
            if (rev_valid[fwd_q1] && rev_rd == irq_idx) begin
              ex_rev_clr = 1'b1;
            end
          end
        end
        iva_pkg::OP_LOOKUP: begin
          if (fwd_valid[irq_idx]) begin
            ex_vvalid = 1'b1;
            ex_vout   = iva_pkg::VEC_IN_W'(fwd_q1);
          end
        end
        iva_pkg::OP_DISPATCH: begin
          if (!vec_ok) begin
            ex_status = iva_pkg::ST_SPURIOUS;
          end else if (!rev_valid[vec_idx]) begin
            ex_status = iva_pkg::ST_SPURIOUS;
          end else if (fwd_valid[rev_q1] && fwd_rd == vec_idx) begin
            ex_deliver = 1'b1;
            ex_iout    = iva_pkg::IRQ_OUT_W'(rev_q1);
          end else begin
            ex_status = iva_pkg::ST_STALE;
          end
        end
        default: begin
          ex_status = iva_pkg::ST_OK;
        end
      endcase
    end
  end

  // Table write port selection
  always_comb begin
    fwd_wa  = irq_idx;
    fwd_wd  = vec_idx;
    rev_wa  = ex_rev_addr;
    rev_wd  = irq_idx;
    fwd_set = cmd.exec_fire && ex_fwd_set;
    fwd_clr = cmd.exec_fire && ex_fwd_clr;
    rev_set = cmd.exec_fire && ex_rev_set;
    rev_clr = cmd.exec_fire && ex_rev_clr;
    if (cmd.alloc_fire) begin
      fwd_wd  = scan_vec[VEC_W-1:0];
      rev_wa  = scan_vec[VEC_W-1:0];
      fwd_set = scan_found;
      rev_set = scan_found;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec_fire || cmd.alloc_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec_fire) begin
      status       <= ex_status;
      vector_valid <= ex_vvalid;
      vector_out   <= ex_vout;
      deliver      <= ex_deliver;
      irq_out      <= ex_iout;
    end else if (cmd.alloc_fire) begin
      status       <= scan_found ? iva_pkg::ST_OK : iva_pkg::ST_NO_FREE;
      vector_valid <= scan_found;
      vector_out   <= scan_found ? scan_vec : '0;
      deliver      <= 1'b0;
      irq_out      <= '0;
    end
  end

  assign sts.need_scan = ex_need_scan;
  assign sts.out_free  = out_free;
  assign sts.scan_hit  = lane_hit;
  assign sts.scan_last = scan_chunk == cfg.dyn_end[iva_pkg::VEC_IN_W-1:LW];

endmodule

// ===== rtl/interrupt_vector_allocator_unit.sv =====
// Interrupt vector allocator with forward and reverse binding tables.
// Request channel in, result channel out, APB-style register port for the
// dynamic range and fixed start. Each request names bind, alloc, free,
// lookup or dispatch and yields exactly one result transaction.
// Flow: a request is accepted, the tables are read in two dependent
// phases (forward then reverse, or reverse then forward), and the result is
// loaded into the output register as soon as that register is free.
// An alloc that has to search for a free vector scans the reverse valid bits
// 16 vectors per cycle from dynamic_start towards dynamic_end, stopping at the
// first chunk that holds a free vector in range; the lowest such vector wins.
// One request is in flight at a time; in_ready is high only while the unit
// waits for a request, even if an earlier result still sits in the output
// register. If the receiver stalls, the unit holds the new result internally
// until the output register is taken, then returns to accepting requests.
// Reset empties both tables (all valid bits clear at once, no clearing
// pass) and loads dynamic_start 32, dynamic_end 223, fixed_start 224.
// Registers: 0x0 dynamic_start, 0x4 dynamic_end, 0x8 fixed_start (bits 7:0).
`timescale 1ns / 1ps

module interrupt_vector_allocator_unit #(
  parameter int NUM_IRQS    = iva_pkg::NUM_IRQS_DEF,
  parameter int NUM_VECTORS = iva_pkg::NUM_VECTORS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [iva_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [iva_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [iva_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [iva_pkg::OP_W-1:0]         operation,
  input  logic [iva_pkg::IRQ_IN_W-1:0]     irq_number,
  input  logic [iva_pkg::VEC_IN_W-1:0]     vector_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [iva_pkg::STATUS_W-1:0]     status,
  output logic                             vector_valid,
  output logic [iva_pkg::VEC_IN_W-1:0]     vector_out,
  output logic                             deliver,
  output logic [iva_pkg::IRQ_OUT_W-1:0]    irq_out
);

  iva_pkg::iva_cfg_t cfg;
  iva_pkg::iva_cmd_t cmd;
  iva_pkg::iva_sts_t sts;
  logic [1:0]        reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[iva_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dyn_start <= iva_pkg::DYN_START_RST;
      cfg.dyn_end   <= iva_pkg::DYN_END_RST;
      cfg.fix_start <= iva_pkg::FIX_START_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        iva_pkg::REG_DYN_START: cfg.dyn_start <= pwdata[7:0];
        iva_pkg::REG_DYN_END:   cfg.dyn_end   <= pwdata[7:0];
        iva_pkg::REG_FIX_START: cfg.fix_start <= pwdata[7:0];
        default: begin
          // unmapped register: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      iva_pkg::REG_DYN_START: prdata = {24'd0, cfg.dyn_start};
      iva_pkg::REG_DYN_END:   prdata = {24'd0, cfg.dyn_end};
      iva_pkg::REG_FIX_START: prdata = {24'd0, cfg.fix_start};
      default:                prdata = '0;
    endcase
  end

  iva_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iva_datapath #(
    .NUM_IRQS    (NUM_IRQS),
    .NUM_VECTORS (NUM_VECTORS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .operation    (operation),
    .irq_number   (irq_number),
    .vector_in    (vector_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .vector_valid (vector_valid),
    .vector_out   (vector_out),
    .deliver      (deliver),
    .irq_out      (irq_out)
  );

endmodule

// ===== tb/interrupt_vector_allocator_unit_test.sv =====
// Self-checking testbench for interrupt_vector_allocator_unit: directed and random
// bind/alloc/free/lookup/dispatch traffic under several register settings.
// Depends on iva_pkg and the unit itself; the scoreboard keeps its own binding tables.
`timescale 1ns / 1ps

module interrupt_vector_allocator_unit_test;

  localparam int IRQ_COUNT = iva_pkg::NUM_IRQS_DEF;
  localparam int VEC_COUNT = iva_pkg::NUM_VECTORS_DEF;
  localparam logic [iva_pkg::OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [iva_pkg::OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam int SEGMENT_ITEMS = 250;
  localparam int SEGMENT_COUNT = 6;

  typedef struct packed {
    logic [iva_pkg::STATUS_W-1:0]  status;
    logic                          vector_valid;
    logic [iva_pkg::VEC_IN_W-1:0]  vector_out;
    logic                          deliver;
    logic [iva_pkg::IRQ_OUT_W-1:0] irq_out;
  } vector_result_t;

  class binding_scoreboard;
    bit                           fwd_valid [IRQ_COUNT];
    bit [iva_pkg::VEC_IN_W-1:0]   fwd_vec   [IRQ_COUNT];
    bit                           rev_valid [VEC_COUNT];
    bit [iva_pkg::IRQ_IN_W-1:0]   rev_irq   [VEC_COUNT];
    logic [7:0] dyn_start = iva_pkg::DYN_START_RST;
    logic [7:0] dyn_end   = iva_pkg::DYN_END_RST;
    logic [7:0] fix_start = iva_pkg::FIX_START_RST;
    vector_result_t awaited_results [$];
    int checked = 0;
    int errors  = 0;

    function void set_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        iva_pkg::REG_DYN_START: dyn_start = value;
        iva_pkg::REG_DYN_END:   dyn_end   = value;
        iva_pkg::REG_FIX_START: fix_start = value;
        default: ;
      endcase
    endfunction

    // Update the tables for one request and return the result it causes
    function vector_result_t apply_request(logic [iva_pkg::OP_W-1:0] op,
                                           logic [iva_pkg::IRQ_IN_W-1:0] irq,
                                           logic [iva_pkg::VEC_IN_W-1:0] vec);
      vector_result_t res;
      int v;
      int owner;
      bit found;
      res = '0;
      found = 0;
      if (op <= iva_pkg::OP_LOOKUP && irq >= IRQ_COUNT) begin
        res.status = iva_pkg::ST_BAD_IRQ;
      end else begin
        case (op)
          iva_pkg::OP_BIND: begin
            if (vec >= VEC_COUNT) begin
              res.status = iva_pkg::ST_BAD_IRQ;
            end else begin
              fwd_valid[irq] = 1;
              fwd_vec[irq]   = vec;
              rev_valid[vec] = 1;
              rev_irq[vec]   = irq;
            end
          end
          iva_pkg::OP_ALLOC: begin
            if (fwd_valid[irq]) begin
              v = int'(fwd_vec[irq]);
              if (rev_valid[v] && rev_irq[v] == irq) begin
                res.vector_valid = 1;
                res.vector_out   = iva_pkg::VEC_IN_W'(v);
              end else begin
                res.status = iva_pkg::ST_MISMATCH;
              end
            end else begin
              res.status = iva_pkg::ST_NO_FREE;
              for (v = int'(dyn_start); v <= int'(dyn_end) && v < VEC_COUNT && !found;
                   v++) begin
                if (!rev_valid[v]) begin
                  found = 1;
                  fwd_valid[irq] = 1;
                  fwd_vec[irq]   = iva_pkg::VEC_IN_W'(v);
                  rev_valid[v]   = 1;
                  rev_irq[v]     = irq;
                  res.status       = iva_pkg::ST_OK;
                  res.vector_valid = 1;
                  res.vector_out   = iva_pkg::VEC_IN_W'(v);
                end
              end
            end
          end
          iva_pkg::OP_FREE: begin
            if (fwd_valid[irq] && fwd_vec[irq] < fix_start) begin
              v = int'(fwd_vec[irq]);
              fwd_valid[irq] = 0;
              fwd_vec[irq]   = '0;
              // drop the reverse entry only when it still names this IRQ
              if (rev_valid[v] && rev_irq[v] == irq) begin
                rev_valid[v] = 0;
                rev_irq[v]   = '0;
              end
            end
          end
          iva_pkg::OP_LOOKUP: begin
            if (fwd_valid[irq]) begin
              res.vector_valid = 1;
              res.vector_out   = fwd_vec[irq];
            end
          end
          iva_pkg::OP_DISPATCH: begin
            if (vec >= VEC_COUNT || !rev_valid[vec]) begin
              res.status = iva_pkg::ST_SPURIOUS;
            end else begin
              owner = int'(rev_irq[vec]);
              if (owner < IRQ_COUNT && fwd_valid[owner] && fwd_vec[owner] == vec) begin
                res.deliver = 1;
                res.irq_out = owner[iva_pkg::IRQ_OUT_W-1:0];
              end else begin
                res.status = iva_pkg::ST_STALE;
              end
            end
          end
          default: ;
        endcase
      end
      return res;
    endfunction

    function void note_request(logic [iva_pkg::OP_W-1:0] op,
                               logic [iva_pkg::IRQ_IN_W-1:0] irq,
                               logic [iva_pkg::VEC_IN_W-1:0] vec);
      awaited_results.push_back(apply_request(op, irq, vec));
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(vector_result_t got);
      vector_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("vector_valid", 32'(want.vector_valid), 32'(got.vector_valid));
      compare_field("vector_out", 32'(want.vector_out), 32'(got.vector_out));
      compare_field("deliver", 32'(want.deliver), 32'(got.deliver));
      compare_field("irq_out", 32'(want.irq_out), 32'(got.irq_out));
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [iva_pkg::CFG_ADDR_W-1:0] paddr;
  logic [iva_pkg::CFG_DATA_W-1:0] pwdata;
  logic [iva_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid;
  logic                           in_ready;
  logic [iva_pkg::OP_W-1:0]       operation;
  logic [iva_pkg::IRQ_IN_W-1:0]   irq_number;
  logic [iva_pkg::VEC_IN_W-1:0]   vector_in;
  logic                           out_valid;
  logic                           out_ready;
  logic [iva_pkg::STATUS_W-1:0]   status;
  logic                           vector_valid;
  logic [iva_pkg::VEC_IN_W-1:0]   vector_out;
  logic                           deliver;
  logic [iva_pkg::IRQ_OUT_W-1:0]  irq_out;

  binding_scoreboard tracker;
  int send_idle_pct = 38;
  int recv_idle_pct = 73;
  int hold_left     = 0;
  int requests_sent = 0;
  int settings_used = 0;

  interrupt_vector_allocator_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .irq_number(irq_number), .vector_in(vector_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .vector_valid(vector_valid), .vector_out(vector_out),
    .deliver(deliver), .irq_out(irq_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Timeout: %0d requests sent, %0d results still awaited",
             requests_sent, tracker.awaited_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: check every transaction, randomize ready, honor long hold-offs
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_result({status, vector_valid, vector_out, deliver, irq_out});
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_request(input logic [iva_pkg::OP_W-1:0] op,
                              input logic [iva_pkg::IRQ_IN_W-1:0] irq,
                              input logic [iva_pkg::VEC_IN_W-1:0] vec);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    irq_number <= irq;
    vector_in  <= vec;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(op, irq, vec);
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  task automatic apply_setting(input logic [7:0] lo, input logic [7:0] hi,
                               input logic [7:0] fixed);
    drain_results();
    write_register(iva_pkg::REG_DYN_START, lo);
    write_register(iva_pkg::REG_DYN_END, hi);
    write_register(iva_pkg::REG_FIX_START, fixed);
    settings_used++;
  endtask

  task automatic run_directed();
    logic [iva_pkg::OP_W-1:0] op;
    send_request(iva_pkg::OP_LOOKUP, 9'd5, 8'd0);
    send_request(iva_pkg::OP_ALLOC, 9'd5, 8'd0);
    send_request(iva_pkg::OP_ALLOC, 9'd5, 8'd0);
    send_request(iva_pkg::OP_LOOKUP, 9'd5, 8'd0);
    send_request(iva_pkg::OP_DISPATCH, 9'd0, 8'd32);
    send_request(iva_pkg::OP_DISPATCH, 9'd0, 8'd33);
    send_request(iva_pkg::OP_BIND, 9'd511, 8'd10);
    send_request(iva_pkg::OP_ALLOC, 9'd256, 8'd0);
    send_request(iva_pkg::OP_FREE, 9'd300, 8'd0);
    send_request(iva_pkg::OP_LOOKUP, 9'd257, 8'd0);
    send_request(iva_pkg::OP_BIND, 9'd255, 8'd255);
    send_request(iva_pkg::OP_FREE, 9'd255, 8'd0);
    send_request(iva_pkg::OP_LOOKUP, 9'd255, 8'd0);
    send_request(iva_pkg::OP_DISPATCH, 9'd511, 8'd255);
    // rebind vector 32 to another IRQ so IRQ 5 holds a stale pair
    send_request(iva_pkg::OP_BIND, 9'd7, 8'd32);
    send_request(iva_pkg::OP_ALLOC, 9'd5, 8'd0);
    send_request(iva_pkg::OP_DISPATCH, 9'd0, 8'd32);
    send_request(iva_pkg::OP_BIND, 9'd7, 8'd40);
    send_request(iva_pkg::OP_DISPATCH, 9'd0, 8'd32);
    send_request(iva_pkg::OP_FREE, 9'd5, 8'd0);
    send_request(iva_pkg::OP_FREE, 9'd9, 8'd0);
    send_request(iva_pkg::OP_BIND, 9'd0, 8'd0);
    send_request(iva_pkg::OP_DISPATCH, 9'd0, 8'd0);
    for (op = OP_UNUSED_FIRST; op != OP_UNUSED_LAST; op++) send_request(op, 9'd511, 8'd255);
    send_request(OP_UNUSED_LAST, 9'd0, 8'd0);
    // empty range, then a one-vector range that runs out
    apply_setting(8'd200, 8'd100, iva_pkg::FIX_START_RST);
    send_request(iva_pkg::OP_ALLOC, 9'd20, 8'd0);
    apply_setting(8'd41, 8'd41, iva_pkg::FIX_START_RST);
    send_request(iva_pkg::OP_ALLOC, 9'd21, 8'd0);
    send_request(iva_pkg::OP_ALLOC, 9'd22, 8'd0);
  endtask

  task automatic run_random(input int count, input bit with_hold);
    int i;
    int pick;
    logic [iva_pkg::OP_W-1:0]     op;
    logic [iva_pkg::IRQ_IN_W-1:0] irq;
    logic [iva_pkg::VEC_IN_W-1:0] vec;
    for (i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) hold_left = 300;
      pick = $urandom_range(99);
      if (pick < 70) irq = iva_pkg::IRQ_IN_W'($urandom_range(47));
      else if (pick < 90) irq = iva_pkg::IRQ_IN_W'($urandom_range(255));
      else irq = iva_pkg::IRQ_IN_W'($urandom_range(511));
      if ($urandom_range(1) == 0 && tracker.dyn_start <= tracker.dyn_end) begin
        vec = iva_pkg::VEC_IN_W'($urandom_range(tracker.dyn_end, tracker.dyn_start));
      end else begin
        vec = iva_pkg::VEC_IN_W'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 18) op = iva_pkg::OP_BIND;
      else if (pick < 43) op = iva_pkg::OP_ALLOC;
      else if (pick < 63) op = iva_pkg::OP_FREE;
      else if (pick < 73) op = iva_pkg::OP_LOOKUP;
      else if (pick < 95) op = iva_pkg::OP_DISPATCH;
      else op = iva_pkg::OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
      // aim most dispatches at a vector some pooled IRQ holds
      if (op == iva_pkg::OP_DISPATCH && $urandom_range(99) < 60) begin
        vec = tracker.fwd_vec[$urandom_range(47)];
      end
      send_request(op, irq, vec);
    end
  endtask

  initial begin
    int seg;
    tracker = new();
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    operation  <= iva_pkg::OP_BIND;
    irq_number <= '0;
    vector_in  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    for (seg = 0; seg < SEGMENT_COUNT; seg++) begin
      case (seg)
        0: apply_setting(iva_pkg::DYN_START_RST, iva_pkg::DYN_END_RST,
                         iva_pkg::FIX_START_RST);
        1: apply_setting(8'd0, 8'd255, 8'd255);
        2: apply_setting(8'd255, 8'd0, 8'd0);
        3: apply_setting(8'd100, 8'd107, 8'd104);
        4: apply_setting(8'd240, 8'd255, 8'd128);
        default: apply_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)));
      endcase
      if (seg < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 73;
      end else if (seg < 4) begin
        send_idle_pct = 73;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_random(SEGMENT_ITEMS, seg == 4);
    end

    drain_results();
    repeat (25) @(posedge clk);
    $display("Sent %0d requests across %0d register settings; %0d results checked.",
             requests_sent, settings_used, tracker.checked);
    $display("Mismatches found: %0d", tracker.errors);
    if (tracker.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
